// ===== hdl/pwm_sliding_window_scorer_defines.svh =====
// Assertion macros used by the port checker of the scorer.
`ifndef PWM_SLIDING_WINDOW_SCORER_DEFINES_SVH
`define PWM_SLIDING_WINDOW_SCORER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SWS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scorer check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SWS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scorer check failed");

// Next-cycle implication that is also checked during reset.
`define SWS_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("scorer reset check failed");

`endif

// ===== hdl/sws_pkg.sv =====
package sws_pkg;

    localparam int MAX_MOTIF_LEN = 32;
    localparam int NUM_BASES     = 4;
    localparam int WEIGHT_BITS   = 16;

    localparam int COL_W   = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int ALEN_W  = $clog2(MAX_MOTIF_LEN + 1);
    localparam int BSEL_W  = $clog2(NUM_BASES);
    localparam int LEN_W   = 6;
    localparam int SCORE_W = 21;
    localparam int IDX_W   = 16;
    localparam int WIN_W   = 16;
    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int BASE_W  = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - SCORE_W - IDX_W;
    localparam int ACC_W   = ((SCORE_W > WEIGHT_BITS) ? SCORE_W : WEIGHT_BITS) + 1;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EOL  = 2'd2;

    localparam logic CFG_LEN = 1'b0;
    localparam logic CFG_THR = 1'b1;

    typedef struct packed {
        logic                          scan;
        logic                          clear;
        logic                          base_vld;
        logic [BSEL_W-1:0]             base;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_cell_ctrl;

    // Clamp an incoming Q8.8 weight to the stored weight width.
    function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
        input logic signed [WIN_W-1:0] w
    );
        logic signed [33:0] v;
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        v  = 34'(w);
        hi = (34'sd1 <<< (WEIGHT_BITS - 1)) - 34'sd1;
        lo = -(34'sd1 <<< (WEIGHT_BITS - 1));
        if (v > hi) begin
            v = hi;
        end else if (v < lo) begin
            v = lo;
        end
        return v[WEIGHT_BITS-1:0];
    endfunction

    // Clamp a widened sum to the signed score range.
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [SCORE_W-1:0] r;
        hi = ACC_W'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
        lo = ACC_W'(-(64'sd1 <<< (SCORE_W - 1)));
        if (v > hi) begin
            r = hi[SCORE_W-1:0];
        end else if (v < lo) begin
            r = lo[SCORE_W-1:0];
        end else begin
            r = v[SCORE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/sws_cell.sv =====
// One matrix column: its weights and the partial sum that passes through it.
module sws_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sws_pkg::t_cell_ctrl                    i_ctrl,
    input  logic                                   i_ld_en,
    input  logic signed [sws_pkg::SCORE_W-1:0]     i_sum_prev,
    output logic signed [sws_pkg::SCORE_W-1:0]     o_sum,
    output logic signed [sws_pkg::SCORE_W-1:0]     o_sum_nxt
);
    import sws_pkg::*;

    logic signed [WEIGHT_BITS-1:0] r_wt [NUM_BASES];
    logic signed [SCORE_W-1:0]     r_sum;
    logic signed [SCORE_W-1:0]     n_sum;
    logic signed [ACC_W-1:0]       add;

    // weights stay undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_ld_en) begin
            r_wt[i_ctrl.base] <= i_ctrl.weight;
        end
    end

    always_comb begin
        add = i_ctrl.base_vld ? ACC_W'(r_wt[i_ctrl.base]) : '0;
        n_sum = sat_score(ACC_W'(i_sum_prev) + add);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.scan) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum     = r_sum;
    assign o_sum_nxt = n_sum;

endmodule

// ===== hdl/sws_out_stage.sv =====
// Output register: threshold compare and hold under back-pressure.
module sws_out_stage (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic signed [sws_pkg::SCORE_W-1:0]     i_score,
    input  logic [sws_pkg::IDX_W-1:0]              i_index,
    input  logic signed [sws_pkg::SCORE_W-1:0]     i_thr,
    input  logic                                   i_ready,
    output logic                                   o_free,
    output logic                                   o_vld,
    output logic signed [sws_pkg::SCORE_W-1:0]     o_score,
    output logic                                   o_hit,
    output logic [sws_pkg::IDX_W-1:0]              o_index
);
    import sws_pkg::*;

    logic                      r_vld;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_index;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_vld) begin
            r_score <= i_score;
            r_hit   <= (i_score >= i_thr);
            r_index <= i_index;
        end
    end

    assign o_vld   = r_vld;
    assign o_score = r_score;
    assign o_hit   = r_hit;
    assign o_index = r_index;

endmodule

// ===== hdl/pwm_sliding_window_scorer.sv =====
// Channel      | Dir | Handshake                     | Payload
// s_axis       | in  | s_axis_tvalid / s_axis_tready | tuser command, tdata position/base/weight
// m_axis       | out | m_axis_tvalid / m_axis_tready | tdata score/window index, tuser hit
// cfg          | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per clock while s_axis_tready is high: all column cells update their sums together.
// A window result passes the select stage, then the output register where the
// threshold compare lands.
// Reset is synchronous, active low: clear sums and counters, set motif length
// to 16 and threshold to 0; weights keep their values.
// A stalled output holds; input ready drops only while both stages are full and m_axis stalls.
module pwm_sliding_window_scorer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] position, [7:5] base_code, [23:8] weight
    input  logic [sws_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  logic [sws_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [20:0] score, [36:21] window_index, [39:37] zero
    output logic [sws_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] hit
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [sws_pkg::SCORE_W-1:0]       i_cfg_data
);
    import sws_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]          r_len;
    logic signed [SCORE_W-1:0] r_thr;

    // Line state
    logic [ALEN_W-1:0]         r_bs;
    logic [ALEN_W-1:0]         n_bs;
    logic [IDX_W-1:0]          r_win;

    // Select stage
    logic                      r_s1_vld;
    logic signed [SCORE_W-1:0] r_s1_score;
    logic [IDX_W-1:0]          r_s1_index;

    logic                      in_acc;
    logic [CMD_W-1:0]          cmd;
    logic [POS_W-1:0]          pos;
    logic [BASE_W-1:0]         base_code;
    logic signed [WIN_W-1:0]   win_weight;
    logic                      is_scan;
    logic                      emit;
    logic [ALEN_W-1:0]         act_len;
    logic [COL_W-1:0]          last_col;
    t_cell_ctrl                ctrl;
    logic [MAX_MOTIF_LEN-1:0]  ld_en;
    logic                      out_free;
    logic signed [SCORE_W-1:0] out_score;
    logic [IDX_W-1:0]          out_index;

    logic signed [SCORE_W-1:0] sum     [MAX_MOTIF_LEN];
    logic signed [SCORE_W-1:0] sum_nxt [MAX_MOTIF_LEN];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(16);
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEN: r_len <= i_cfg_data[LEN_W-1:0];
                CFG_THR: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the item
    assign cmd        = s_axis_tuser;
    assign pos        = s_axis_tdata[POS_W-1:0];
    assign base_code  = s_axis_tdata[POS_W+BASE_W-1:POS_W];
    assign win_weight = s_axis_tdata[POS_W+BASE_W+WIN_W-1:POS_W+BASE_W];

    assign s_axis_tready = !r_s1_vld || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_scan       = in_acc && (cmd == CMD_SCAN);

    // Clamp the window length to the number of columns; zero acts as one.
    always_comb begin
        if (r_len == '0) begin
            act_len = ALEN_W'(1);
        end else if (int'(r_len) > MAX_MOTIF_LEN) begin
            act_len = ALEN_W'(MAX_MOTIF_LEN);
        end else begin
            act_len = ALEN_W'(r_len);
        end
        last_col = COL_W'(act_len - ALEN_W'(1));
    end

    // Broadcast control to the cells
    always_comb begin
        ctrl.scan     = is_scan;
        ctrl.clear    = in_acc && (cmd == CMD_EOL);
        ctrl.base_vld = (int'(base_code) < NUM_BASES);
        ctrl.base     = base_code[BSEL_W-1:0];
        ctrl.weight   = sat_weight(win_weight);
    end

    genvar k;
    generate
        for (k = 0; k < MAX_MOTIF_LEN; k++) begin : g_cell
            logic signed [SCORE_W-1:0] prev;
            if (k == 0) begin : g_head
                assign prev = '0;
            end else begin : g_link
                assign prev = sum[k-1];
            end
            assign ld_en[k] = in_acc && (cmd == CMD_LOAD) && ctrl.base_vld
                              && (int'(pos) == k);
            sws_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (ctrl),
                .i_ld_en    (ld_en[k]),
                .i_sum_prev (prev),
                .o_sum      (sum[k]),
                .o_sum_nxt  (sum_nxt[k])
            );
        end
    endgenerate

    // Count bases on the line; a window completes once the length is reached.
    always_comb begin
        n_bs = r_bs;
        if (int'(r_bs) < MAX_MOTIF_LEN) begin
            n_bs = r_bs + ALEN_W'(1);
        end
        emit = is_scan && (n_bs >= act_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && cmd == CMD_EOL)) begin
            r_bs  <= '0;
            r_win <= '0;
        end else if (is_scan) begin
            r_bs <= n_bs;
            if (emit && r_win != IDX_MAX) begin
                r_win <= r_win + IDX_W'(1);
            end
        end
    end

    // Select stage: take the sum leaving the last active column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_score <= sum_nxt[last_col];
            r_s1_index <= r_win;
        end
    end

    sws_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s1_vld),
        .i_score (r_s1_score),
        .i_index (r_s1_index),
        .i_thr   (r_thr),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_vld   (m_axis_tvalid),
        .o_score (out_score),
        .o_hit   (m_axis_tuser),
        .o_index (out_index)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_index, out_score};

endmodule

// ===== hdl/sws_checker.sv =====
`include "pwm_sliding_window_scorer_defines.svh"

// Port-level checks on the scorer.
module sws_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sws_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sws_pkg::*;

    // hold a stalled result
    `SWS_ASSERT_NXT(a_out_hold_vld, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SWS_ASSERT_NXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // reset drains the output
    `SWS_ASSERT_RST(a_rst_clear, !i_rst_n, !m_axis_tvalid)

    // a result appearing on an empty output follows an accepted input item through both stages
    `SWS_ASSERT_IMP(a_out_latency, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind pwm_sliding_window_scorer sws_checker u_sws_checker (.*);
